// ===== hdl/isort_pkg.sv =====
package isort_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic  ins;    // insert value this cycle
    logic  shift;  // drain: move every entry one cell toward the output
    data_t value;  // value being inserted
  } ctrl_t;

endpackage

// ===== hdl/isort_cell.sv =====
module isort_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  isort_pkg::ctrl_t    ctrl,
  input  logic                prev_gt,
  input  logic                prev_valid,
  input  isort_pkg::data_t    prev_value,
  input  logic                next_valid,
  input  isort_pkg::data_t    next_value,
  output logic                gt,
  output logic                valid,
  output isort_pkg::data_t    value
);

  logic             valid_r;
  logic             valid_nxt;
  isort_pkg::data_t value_r;
  isort_pkg::data_t value_nxt;

  // empty cell counts as +infinity
  assign gt    = !valid_r || (value_r > ctrl.value);
  assign valid = valid_r;
  assign value = value_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      valid_nxt = next_valid;
      value_nxt = next_value;
    end else if (ctrl.ins && gt) begin
      valid_nxt = valid_r | prev_valid;
      value_nxt = prev_gt ? prev_value : ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== hdl/insertion_sorter.sv =====
// Streaming insertion sorter for signed 32-bit values. While a list is being
// loaded one element is accepted per cycle: the new value is compared against
// every cell of a chain of CAPACITY cells at once, and all larger entries step
// one cell up to open its slot, so equal values keep arrival order. Elements
// arriving with the chain full are dropped and flag overflow (out_tuser) on
// every result of that list. The element carrying in_tlast is inserted too,
// then the chain shifts toward the output one entry per cycle while out_tready
// is high: a list of N held values drains as N results, during which in_tready
// is low. The last result carries out_tlast and the sorter is then empty.
module insertion_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic signed [31:0]      in_tdata,   // [31:0] value
  input  logic                    in_tlast,   // last
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic signed [31:0]      out_tdata,  // [31:0] value_res
  output logic                    out_tlast,  // last_res
  output logic                    out_tuser   // [0] overflow
);

  isort_pkg::state_t state_r;
  isort_pkg::state_t state_nxt;
  logic              dropped_r;
  logic              dropped_nxt;
  isort_pkg::ctrl_t  ctrl;

  logic             gt    [CAPACITY];
  logic             valid [CAPACITY];
  isort_pkg::data_t value [CAPACITY];

  logic out_xact;
  logic full;

  assign full     = valid[CAPACITY-1];
  assign out_xact = out_tvalid && out_tready;

  assign out_tdata = value[0];
  assign out_tlast = !valid[1];
  assign out_tuser = dropped_r;

  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.value  = in_tdata;
    unique case (state_r)
      isort_pkg::ST_FILL: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.ins = !full;
          if (full) begin
            dropped_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = isort_pkg::ST_DRAIN;
          end
        end
      end
      isort_pkg::ST_DRAIN: begin
        out_tvalid = 1'b1;
        ctrl.shift = out_tready;
        if (out_tready && !valid[1]) begin
          state_nxt   = isort_pkg::ST_FILL;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = isort_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= isort_pkg::ST_FILL;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             p_gt;
    logic             p_valid;
    isort_pkg::data_t p_value;
    logic             n_valid;
    isort_pkg::data_t n_value;

    if (i == 0) begin : g_head
      assign p_gt    = 1'b0;
      assign p_valid = 1'b1;
      assign p_value = in_tdata;
    end else begin : g_body
      assign p_gt    = gt[i-1];
      assign p_valid = valid[i-1];
      assign p_value = value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_value = value[i];
    end else begin : g_inner
      assign n_valid = valid[i+1];
      assign n_value = value[i+1];
    end

    isort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_gt    (p_gt),
      .prev_valid (p_valid),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .gt         (gt[i]),
      .valid      (valid[i]),
      .value      (value[i])
    );
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == isort_pkg::ST_DRAIN |-> valid[0])
    else $error("draining with an empty head cell");

  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    valid[1] |-> valid[0])
    else $error("occupied cells not packed toward the output");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_xact && out_tlast |=> !valid[0] && !dropped_r)
    else $error("store not empty after final result");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == isort_pkg::ST_DRAIN && valid[1] |-> value[0] <= value[1])
    else $error("head of chain out of order");

endmodule
